// ===== src/usbmsx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbmsx_pkg
// shared types, codes and helpers of the usb-midi sysex reassembler
// ----------------------------------------------------------------------------
package usbmsx_pkg;

  // default message buffer size in bytes, per slot
  localparam int BUF_BYTES_DEF = 512;

  // code index numbers and sysex start byte
  localparam logic [3:0] CIN_MASK    = 4'hF;
  localparam logic [3:0] CIN_CONT    = 4'h4;
  localparam logic [3:0] CIN_END1    = 4'h5;
  localparam logic [3:0] CIN_END2    = 4'h6;
  localparam logic [3:0] CIN_END3    = 4'h7;
  localparam logic [7:0] SYSEX_START = 8'hF0;

  localparam logic [9:0] LEN_OUT_MAX = 10'd1023;

  typedef enum logic [1:0] {
    REQ_PACKET  = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_GONE    = 2'd3
  } req_e;

  // one accepted request item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pkt_header;
    logic [7:0]  pkt_byte1;
    logic [7:0]  pkt_byte2;
    logic [7:0]  pkt_byte3;
    logic [8:0]  read_index;
    logic [15:0] read_limit;
  } req_t;

  // per-item result status handed down the pipeline
  typedef struct packed {
    logic       completed;
    logic       message_ready;
    logic [9:0] length_out;
    logic       read_hit;
  } step_t;

  function automatic logic [9:0] clamp_len(logic [15:0] v);
    logic [9:0] r;
    r = (v > 16'(LEN_OUT_MAX)) ? LEN_OUT_MAX : v[9:0];
    return r;
  endfunction

endpackage

// ===== src/usbmsx_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbmsx_req_if
// request channel: event packets, byte reads, release and device-gone
// ----------------------------------------------------------------------------
interface usbmsx_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  pkt_header;
  logic [7:0]  pkt_byte1;
  logic [7:0]  pkt_byte2;
  logic [7:0]  pkt_byte3;
  logic [8:0]  read_index;
  logic [15:0] read_limit;

  modport source (
    output valid, req_type, pkt_header, pkt_byte1, pkt_byte2, pkt_byte3,
           read_index, read_limit,
    input  ready
  );
  modport sink (
    input  valid, req_type, pkt_header, pkt_byte1, pkt_byte2, pkt_byte3,
           read_index, read_limit,
    output ready
  );
endinterface

// ===== src/usbmsx_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbmsx_rsp_if
// result channel: one result item per request item
// ----------------------------------------------------------------------------
interface usbmsx_rsp_if;
  logic       valid;
  logic       ready;
  logic       completed;
  logic       message_ready;
  logic [7:0] byte_out;
  logic [9:0] length_out;

  modport source (
    output valid, completed, message_ready, byte_out, length_out,
    input  ready
  );
  modport sink (
    input  valid, completed, message_ready, byte_out, length_out,
    output ready
  );
endinterface

// ===== src/usbmsx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbmsx_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module usbmsx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/usbmsx_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbmsx_seq
// message state: assembly, slot lengths, ready slot; decodes and, on fire_i, commits at most one item a cycle
// ----------------------------------------------------------------------------
module usbmsx_seq #(
  parameter int BUF_BYTES = usbmsx_pkg::BUF_BYTES_DEF,
  localparam int ADDR_W = $clog2(2 * BUF_BYTES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  usbmsx_pkg::req_t      req_i,
  output usbmsx_pkg::step_t     step_o,
  output logic [2:0]            wr_en_o,
  output logic [ADDR_W-1:0]     wr_base_o,
  output logic [2:0][7:0]       wr_data_o,
  output logic                  rd_en_o,
  output logic [ADDR_W-1:0]     rd_addr_o
);

  localparam int LEN_W = $clog2(BUF_BYTES + 1);
  localparam logic [LEN_W:0] BUF_LIM = (LEN_W + 1)'(BUF_BYTES);

  logic [LEN_W-1:0] slot_len_q [2];
  logic [LEN_W-1:0] slot_len_d [2];
  logic             write_slot_q, write_slot_d;
  logic             ready_valid_q, ready_valid_d;
  logic             ready_slot_q, ready_slot_d;
  logic [LEN_W-1:0] asm_len_q, asm_len_d;
  logic             asm_open_q, asm_open_d;

  logic [3:0]       cin;
  logic             is_pkt, is_end, start, append, complete;
  logic [2:0]       want;
  logic [LEN_W-1:0] len_base;
  logic [LEN_W:0]   new_len_w;
  logic [LEN_W-1:0] new_len;
  logic [LEN_W-1:0] rd_len;
  logic [15:0]      rel_len;

  assign cin    = req_i.pkt_header[3:0] & usbmsx_pkg::CIN_MASK;
  assign is_pkt = (usbmsx_pkg::req_e'(req_i.req_type) == usbmsx_pkg::REQ_PACKET);
  assign is_end = (cin == usbmsx_pkg::CIN_END1) || (cin == usbmsx_pkg::CIN_END2) ||
                  (cin == usbmsx_pkg::CIN_END3);
  assign start  = is_pkt && (cin == usbmsx_pkg::CIN_CONT) &&
                  (req_i.pkt_byte1 == usbmsx_pkg::SYSEX_START);
  assign append = is_pkt && (start || asm_open_q) &&
                  ((cin == usbmsx_pkg::CIN_CONT) || is_end);
  assign complete = is_pkt && is_end && asm_open_q;

  assign len_base = start ? '0 : asm_len_q;
  assign want[0]  = append;
  assign want[1]  = append && (cin != usbmsx_pkg::CIN_END1);
  assign want[2]  = append && ((cin == usbmsx_pkg::CIN_CONT) ||
                               (cin == usbmsx_pkg::CIN_END3));

  // bytes past the buffer end are dropped
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wr_en_o[k] = want[k] && (({1'b0, len_base} + (LEN_W + 1)'(k)) < BUF_LIM);
    end
  end

  assign new_len_w = {1'b0, len_base} + (LEN_W + 1)'(wr_en_o[0]) +
                     (LEN_W + 1)'(wr_en_o[1]) + (LEN_W + 1)'(wr_en_o[2]);
  assign new_len   = new_len_w[LEN_W-1:0];

  assign wr_base_o = (write_slot_q ? ADDR_W'(BUF_BYTES) : '0) + ADDR_W'(len_base);
  assign wr_data_o = {req_i.pkt_byte3, req_i.pkt_byte2, req_i.pkt_byte1};

  assign rd_len    = slot_len_q[ready_slot_q];
  assign rel_len   = (16'(rd_len) < req_i.read_limit) ? 16'(rd_len) : req_i.read_limit;
  assign rd_addr_o = (ready_slot_q ? ADDR_W'(BUF_BYTES) : '0) + ADDR_W'(req_i.read_index);

  always_comb begin
    slot_len_d    = slot_len_q;
    write_slot_d  = write_slot_q;
    ready_valid_d = ready_valid_q;
    ready_slot_d  = ready_slot_q;
    asm_len_d     = asm_len_q;
    asm_open_d    = asm_open_q;
    rd_en_o       = 1'b0;
    step_o        = '0;

    unique case (usbmsx_pkg::req_e'(req_i.req_type))
      usbmsx_pkg::REQ_PACKET: begin
        if (complete) begin
          slot_len_d[write_slot_q] = new_len;
          ready_slot_d             = write_slot_q;
          ready_valid_d            = 1'b1;
          write_slot_d             = ~write_slot_q;
          asm_len_d                = '0;
          asm_open_d               = 1'b0;
          step_o.completed         = 1'b1;
          step_o.length_out        = usbmsx_pkg::clamp_len(16'(new_len));
        end else if (append) begin
          asm_len_d  = new_len;
          asm_open_d = 1'b1;
        end
      end
      usbmsx_pkg::REQ_READ: begin
        step_o.read_hit = ready_valid_q &&
                          (16'(req_i.read_index) < 16'(rd_len)) &&
                          (16'(req_i.read_index) < 16'(BUF_BYTES));
        rd_en_o         = fire_i && step_o.read_hit;
      end
      usbmsx_pkg::REQ_RELEASE: begin
        if (ready_valid_q) begin
          step_o.length_out = usbmsx_pkg::clamp_len(rel_len);
          ready_valid_d     = 1'b0;
        end
      end
      usbmsx_pkg::REQ_GONE: begin
        asm_len_d     = '0;
        asm_open_d    = 1'b0;
        ready_valid_d = 1'b0;
      end
    endcase

    step_o.message_ready = ready_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_len_q[0] <= '0;
      slot_len_q[1] <= '0;
      write_slot_q  <= 1'b0;
      ready_valid_q <= 1'b0;
      ready_slot_q  <= 1'b0;
      asm_len_q     <= '0;
      asm_open_q    <= 1'b0;
    end else if (fire_i) begin
      slot_len_q    <= slot_len_d;
      write_slot_q  <= write_slot_d;
      ready_valid_q <= ready_valid_d;
      ready_slot_q  <= ready_slot_d;
      asm_len_q     <= asm_len_d;
      asm_open_q    <= asm_open_d;
    end
  end

endmodule

// ===== src/usbmsx_banks.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbmsx_banks
// message store as four byte banks interleaved on the low address bits
// ----------------------------------------------------------------------------
module usbmsx_banks #(
  parameter int BUF_BYTES = usbmsx_pkg::BUF_BYTES_DEF,
  localparam int ADDR_W = $clog2(2 * BUF_BYTES)
) (
  input  logic                  clk_i,
  input  logic [2:0]            wr_en_i,
  input  logic [ADDR_W-1:0]     wr_base_i,
  input  logic [2:0][7:0]       wr_data_i,
  input  logic                  rd_en_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  output logic [7:0]            rdata_o
);

  localparam int NUM_BANKS = 4;
  localparam int ROWS      = (2 * BUF_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROW_W     = ADDR_W - 2;

  // lane three is a dummy so a free bank indexes in range
  logic [3:0]             lane_en;
  logic [3:0][ADDR_W-1:0] lane_addr;
  logic [3:0][7:0]        lane_data;
  logic [3:0][7:0]        bank_rdata;
  logic [1:0]             sel_q;

  always_comb begin
    lane_en   = {1'b0, wr_en_i};
    lane_data = {8'h00, wr_data_i};
    for (int k = 0; k < NUM_BANKS; k++) begin
      lane_addr[k] = wr_base_i + ADDR_W'(k);
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [1:0]       lane;
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [7:0]       wdata;

    assign lane  = 2'(b) - wr_base_i[1:0];
    assign we    = lane_en[lane];
    assign waddr = lane_addr[lane][ADDR_W-1:2];
    assign wdata = lane_data[lane];

    usbmsx_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (rd_en_i),
      .raddr_i (rd_addr_i[ADDR_W-1:2]),
      .rdata_o (bank_rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sel_q <= rd_addr_i[1:0];
    end
  end

  assign rdata_o = bank_rdata[sel_q];

endmodule

// ===== src/usb_midi_sysex_reassembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_midi_sysex_reassembler
// rebuilds sysex messages from usb-midi event packets into two message slots
// ----------------------------------------------------------------------------
// Takes one request item per clock while the result side does not stall and
// returns exactly one result item for each, in order. Event packets with CIN 4
// start (byte1 = F0) or continue a message,
// CIN 5/6/7 append 1/2/3 bytes and complete it; the finished slot becomes the
// ready message and assembly flips to the other slot. Read requests return a
// byte of the ready message (0 past its length or with none held), release
// returns its length clamped to read_limit and frees it, device-gone drops
// assembly and the ready message. The store is 2 x BUF_BYTES bytes held in
// four byte-wide banks interleaved on the low address bits, so the up to
// three bytes of a packet are written in the same cycle into different banks;
// that bank split lets the store take one item every cycle. An item passes the
// input register, state update plus bank access and output register. The store
// needs no clearing after reset: only bytes below a recorded length are read.
module usb_midi_sysex_reassembler #(
  parameter int BUF_BYTES = usbmsx_pkg::BUF_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  usbmsx_req_if.sink   req_i,
  usbmsx_rsp_if.source rsp_o
);

  localparam int ADDR_W = $clog2(2 * BUF_BYTES);

  // stage a: accepted item
  logic              va_q;
  usbmsx_pkg::req_t  req_a_q;
  // stage b: status waiting for bank read data
  logic              vb_q;
  usbmsx_pkg::step_t step_b_q;
  // stage c: result register
  logic              vc_q;
  logic              completed_q;
  logic              message_ready_q;
  logic [7:0]        byte_out_q;
  logic [9:0]        length_out_q;

  logic ready_b, ready_c;
  logic in_fire, fire_a, adv_b, out_fire;

  usbmsx_pkg::step_t    step_a;
  logic [2:0]           wr_en;
  logic [ADDR_W-1:0]    wr_base;
  logic [2:0][7:0]      wr_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [7:0]           rdata;

  // handshakes: each stage moves when the one after it has room
  assign ready_c  = !vc_q || rsp_o.ready;
  assign ready_b  = !vb_q || ready_c;
  assign req_i.ready = !va_q || ready_b;

  assign in_fire  = req_i.valid && req_i.ready;
  assign fire_a   = va_q && ready_b;
  assign adv_b    = vb_q && ready_c;
  assign out_fire = vc_q && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (in_fire) begin
        va_q <= 1'b1;
      end else if (fire_a) begin
        va_q <= 1'b0;
      end
      if (fire_a) begin
        vb_q <= 1'b1;
      end else if (adv_b) begin
        vb_q <= 1'b0;
      end
      if (adv_b) begin
        vc_q <= 1'b1;
      end else if (out_fire) begin
        vc_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_a_q.req_type   <= req_i.req_type;
      req_a_q.pkt_header <= req_i.pkt_header;
      req_a_q.pkt_byte1  <= req_i.pkt_byte1;
      req_a_q.pkt_byte2  <= req_i.pkt_byte2;
      req_a_q.pkt_byte3  <= req_i.pkt_byte3;
      req_a_q.read_index <= req_i.read_index;
      req_a_q.read_limit <= req_i.read_limit;
    end
    if (fire_a) begin
      step_b_q <= step_a;
    end
    if (adv_b) begin
      completed_q     <= step_b_q.completed;
      message_ready_q <= step_b_q.message_ready;
      length_out_q    <= step_b_q.length_out;
      // byte only on a read that hit the ready message
      byte_out_q      <= step_b_q.read_hit ? rdata : 8'h00;
    end
  end

  // message state and request decode
  usbmsx_seq #(
    .BUF_BYTES (BUF_BYTES)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire_a),
    .req_i     (req_a_q),
    .step_o    (step_a),
    .wr_en_o   (wr_en),
    .wr_base_o (wr_base),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

  // byte store; writes only land when the item advances
  usbmsx_banks #(
    .BUF_BYTES (BUF_BYTES)
  ) u_banks (
    .clk_i     (clk_i),
    .wr_en_i   (fire_a ? wr_en : 3'b000),
    .wr_base_i (wr_base),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rdata_o   (rdata)
  );

  assign rsp_o.valid         = vc_q;
  assign rsp_o.completed     = completed_q;
  assign rsp_o.message_ready = message_ready_q;
  assign rsp_o.byte_out      = byte_out_q;
  assign rsp_o.length_out    = length_out_q;

  // a completing packet always leaves a message ready
  a_complete_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.completed |-> rsp_o.message_ready)
    else $error("completed result without a ready message");

  // a nonzero length outside completion comes from a release, which frees it
  a_release_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.completed && (rsp_o.length_out != 10'd0)
    |-> !rsp_o.message_ready)
    else $error("release left the message ready");

  // a returned byte only comes from a read of a held message
  a_byte_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.byte_out != 8'h00)
    |-> rsp_o.message_ready && !rsp_o.completed && (rsp_o.length_out == 10'd0))
    else $error("byte returned outside a read hit");

  // an item leaving the input register always reaches stage b
  a_stage_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_a |=> vb_q)
    else $error("item lost between input register and stage b");

endmodule
